// ===== hdl/rntt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rntt_pkg
// Shared types, constants and helper functions of the radix number-to-text
// converter: widths, register indexes, controller/datapath bundles and the
// reciprocal table used for division by the radix.
// ----------------------------------------------------------------------------
package rntt_pkg;

   // Widths
   localparam int NUMBER_BITS    = 32;
   localparam int MAX_DIGITS     = 16;
   localparam int DIGIT_BITS     = 4;
   localparam int CHAR_BITS      = 7;
   localparam int BYTE_BITS      = 8;
   localparam int COUNT_BITS     = 5;
   localparam int REM_BITS       = COUNT_BITS + 1;
   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_INDEX_BITS = 2;
   localparam int SLOTS_PER_REG  = CSR_DATA_BITS / BYTE_BITS;
   localparam int STACK_DEPTH    = NUMBER_BITS;
   localparam int DEPTH_BITS     = $clog2(STACK_DEPTH + 1);

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIGIT_COUNT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIGITS_LOW  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIGITS_HIGH = 2'd2;

   // Character limits
   localparam logic [BYTE_BITS-1:0] CHAR_LOWEST  = 8'd32;
   localparam logic [BYTE_BITS-1:0] CHAR_HIGHEST = 8'd126;
   localparam logic [BYTE_BITS-1:0] CHAR_MINUS   = 8'd45;
   localparam logic [BYTE_BITS-1:0] CHAR_PLUS    = 8'd43;

   // Controller commands to the datapath
   typedef struct packed {
      logic load;
      logic val_step;
      logic div_mul;
      logic div_fix;
      logic emit_sign;
      logic emit_digit;
   } rntt_cmd_type;

   // Datapath status to the controller
   typedef struct packed {
      logic count_ok;
      logic row_bad;
      logic row_last;
      logic quot_zero;
      logic negative;
      logic last_digit;
   } rntt_status_type;

   // Alphabet character for digit value k
   function automatic logic [BYTE_BITS-1:0] alpha_char(
      input logic [CSR_DATA_BITS-1:0] low,
      input logic [CSR_DATA_BITS-1:0] high,
      input logic [DIGIT_BITS-1:0]    k
   );
      logic [CSR_DATA_BITS-1:0] word;
      word = k[DIGIT_BITS-1] ? high : low;
      return word[BYTE_BITS*k[DIGIT_BITS-2:0] +: BYTE_BITS];
   endfunction

   // floor(2^32 / radix); estimate is low by at most one
   function automatic logic [NUMBER_BITS-1:0] radix_recip(
      input logic [COUNT_BITS-1:0] radix
   );
      logic [NUMBER_BITS-1:0] r;
      case (radix)
         5'd2:    r = 32'd2147483648;
         5'd3:    r = 32'd1431655765;
         5'd4:    r = 32'd1073741824;
         5'd5:    r = 32'd858993459;
         5'd6:    r = 32'd715827882;
         5'd7:    r = 32'd613566756;
         5'd8:    r = 32'd536870912;
         5'd9:    r = 32'd477218588;
         5'd10:   r = 32'd429496729;
         5'd11:   r = 32'd390451572;
         5'd12:   r = 32'd357913941;
         5'd13:   r = 32'd330382099;
         5'd14:   r = 32'd306783378;
         5'd15:   r = 32'd286331153;
         5'd16:   r = 32'd268435456;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/rntt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rntt_ctrl
// Sequencer of the converter: alphabet check, digit extraction by repeated
// division, then emission of sign and digits, most significant first.
// ----------------------------------------------------------------------------
module rntt_ctrl
   import rntt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  rntt_status_type status,
   output rntt_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_VALIDATE = 6'b000010,
      ST_DIV_MUL  = 6'b000100,
      ST_DIV_FIX  = 6'b001000,
      ST_SIGN     = 6'b010000,
      ST_DIGITS   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_VALIDATE;
            end
         end
         ST_VALIDATE: begin
            if (!status.count_ok || status.row_bad) begin
               state_in = ST_IDLE;
            end else if (status.row_last) begin
               state_in = ST_DIV_MUL;
            end else begin
               cmd.val_step = 1'b1;
            end
         end
         ST_DIV_MUL: begin
            cmd.div_mul = 1'b1;
            state_in    = ST_DIV_FIX;
         end
         ST_DIV_FIX: begin
            cmd.div_fix = 1'b1;
            if (status.quot_zero) begin
               state_in = status.negative ? ST_SIGN : ST_DIGITS;
            end else begin
               state_in = ST_DIV_MUL;
            end
         end
         ST_SIGN: begin
            cmd.emit_sign = 1'b1;
            state_in      = ST_DIGITS;
         end
         ST_DIGITS: begin
            cmd.emit_digit = 1'b1;
            if (status.last_digit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== hdl/rntt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rntt_datapath
// Configuration registers, alphabet checker, reciprocal divider, digit
// stack and the registered result port.
// ----------------------------------------------------------------------------
module rntt_datapath
   import rntt_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_write_data,
   input  logic signed [NUMBER_BITS-1:0] req_number,
   input  rntt_cmd_type                  cmd,
   output rntt_status_type               status,
   output logic                          rsp_valid,
   output logic [CHAR_BITS-1:0]          rsp_character,
   output logic                          rsp_last
);

   // Configuration
   logic [COUNT_BITS-1:0]    count_ff;
   logic [CSR_DATA_BITS-1:0] low_ff;
   logic [CSR_DATA_BITS-1:0] high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         low_ff   <= '0;
         high_ff  <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_DIGIT_COUNT: count_ff <= csr_write_data[COUNT_BITS-1:0];
            CSR_DIGITS_LOW:  low_ff   <= csr_write_data;
            CSR_DIGITS_HIGH: high_ff  <= csr_write_data;
            default:         ;
         endcase
      end
   end

   // Alphabet check, one character per cycle against all later ones
   logic [DIGIT_BITS-1:0] vidx_ff;
   logic [BYTE_BITS-1:0]  row_char;
   logic                  row_dup;

   assign row_char = alpha_char(low_ff, high_ff, vidx_ff);

   always_comb begin
      row_dup = 1'b0;
      for (int b = 0; b < MAX_DIGITS; b++) begin
         if ((COUNT_BITS'(b) > {1'b0, vidx_ff}) && (COUNT_BITS'(b) < count_ff) &&
             (alpha_char(low_ff, high_ff, DIGIT_BITS'(b)) == row_char)) begin
            row_dup = 1'b1;
         end
      end
   end

   assign status.count_ok = (count_ff >= COUNT_BITS'(2)) &&
                            (count_ff <= COUNT_BITS'(MAX_DIGITS));
   assign status.row_bad  = row_dup || (row_char < CHAR_LOWEST) ||
                            (row_char > CHAR_HIGHEST) ||
                            (row_char == CHAR_MINUS) || (row_char == CHAR_PLUS);
   assign status.row_last = (({1'b0, vidx_ff} + COUNT_BITS'(1)) == count_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         vidx_ff <= '0;
      end else if (cmd.val_step) begin
         vidx_ff <= vidx_ff + DIGIT_BITS'(1);
      end
   end

   // Magnitude and sign
   logic [NUMBER_BITS-1:0] num_raw;
   logic [NUMBER_BITS-1:0] mag_ff;
   logic                   neg_ff;
   logic [NUMBER_BITS-1:0] quot_est_ff;

   assign num_raw = NUMBER_BITS'(req_number);

   // Division by the radix: reciprocal multiply, then one-step correction
   logic [2*NUMBER_BITS-1:0] prod;
   logic [NUMBER_BITS-1:0]   radix_w;
   logic [NUMBER_BITS-1:0]   back_prod;
   logic [NUMBER_BITS-1:0]   rem_full;
   logic [REM_BITS-1:0]      rem_small;
   logic                     fix_up;
   logic [REM_BITS-1:0]      rem_fixed;
   logic [DIGIT_BITS-1:0]    digit;
   logic [NUMBER_BITS-1:0]   quot;

   assign prod      = {{NUMBER_BITS{1'b0}}, mag_ff} *
                      {{NUMBER_BITS{1'b0}}, radix_recip(count_ff)};
   assign radix_w   = NUMBER_BITS'(count_ff);
   assign back_prod = quot_est_ff * radix_w;
   assign rem_full  = mag_ff - back_prod;
   assign rem_small = rem_full[REM_BITS-1:0];
   assign fix_up    = (rem_small >= {1'b0, count_ff});
   assign rem_fixed = fix_up ? (rem_small - {1'b0, count_ff}) : rem_small;
   assign digit     = rem_fixed[DIGIT_BITS-1:0];
   assign quot      = quot_est_ff + NUMBER_BITS'(fix_up);

   assign status.quot_zero = (quot == '0);
   assign status.negative  = neg_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff <= num_raw[NUMBER_BITS-1];
         mag_ff <= num_raw[NUMBER_BITS-1] ? (~num_raw + NUMBER_BITS'(1)) : num_raw;
      end else if (cmd.div_fix) begin
         mag_ff <= quot;
      end
      if (cmd.div_mul) begin
         quot_est_ff <= prod[2*NUMBER_BITS-1:NUMBER_BITS];
      end
   end

   // Digit stack: push at the bottom during division, pop from it on emit
   logic [DIGIT_BITS-1:0] stack_ff [STACK_DEPTH];
   logic [DIGIT_BITS-1:0] stack_in [STACK_DEPTH];
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;

   always_comb begin
      stack_in = stack_ff;
      depth_in = depth_ff;
      if (cmd.load) begin
         depth_in = '0;
      end else if (cmd.div_fix) begin
         stack_in[0] = digit;
         for (int i = 1; i < STACK_DEPTH; i++) begin
            stack_in[i] = stack_ff[i-1];
         end
         depth_in = depth_ff + DEPTH_BITS'(1);
      end else if (cmd.emit_digit) begin
         for (int i = 0; i < STACK_DEPTH - 1; i++) begin
            stack_in[i] = stack_ff[i+1];
         end
         depth_in = depth_ff - DEPTH_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      stack_ff <= stack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   assign status.last_digit = (depth_ff == DEPTH_BITS'(1));

   // Result register
   logic                 valid_ff;
   logic [CHAR_BITS-1:0] char_ff;
   logic                 last_ff;
   logic [BYTE_BITS-1:0] top_char;

   assign top_char = alpha_char(low_ff, high_ff, stack_ff[0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.emit_sign || cmd.emit_digit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_sign) begin
         char_ff <= CHAR_MINUS[CHAR_BITS-1:0];
         last_ff <= 1'b0;
      end else if (cmd.emit_digit) begin
         char_ff <= top_char[CHAR_BITS-1:0];
         last_ff <= status.last_digit;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule

// ===== hdl/radix_number_to_text_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_number_to_text_core
// Converts a signed 32-bit number to text in a programmable base of 2 to 16
// digits, one character per result, most significant first.
// ----------------------------------------------------------------------------
// A number is taken when start is high and busy is low. The block first
// checks the alphabet, one character per cycle, and stops early when it
// finds a fault; a bad alphabet ends the job with no output. It then
// extracts digits least significant first, each by a reciprocal multiply
// step and then a correction step, and finally emits an optional
// minus sign and the digits on consecutive cycles, one rsp_valid pulse each,
// rsp_last on the final one. After the transfer busy stays high until the
// last digit has been emitted, so the block cannot take a new number before
// it is through with the current one.
// Results cannot be stalled: the receiver must take each one in the
// cycle it is shown. Write csr_* only while busy is low.
// ----------------------------------------------------------------------------
module radix_number_to_text_core
   import rntt_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [NUMBER_BITS-1:0] req_number,
   output logic                          rsp_valid,
   output logic [CHAR_BITS-1:0]          rsp_character,
   output logic                          rsp_last,
   input  logic                          csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_write_data
);

   rntt_cmd_type    cmd;
   rntt_status_type status;

   // Sequencer
   rntt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Registers, divider, digit stack, result port
   rntt_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_number     (req_number),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_character  (rsp_character),
      .rsp_last       (rsp_last)
   );

endmodule
